/* hw/rtl/assert_macros.svh */
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/kcfi_pkg.sv */
// types and codes for the keyed find-or-insert table
package kcfi_pkg;

    localparam int KEY_W = 45;

    localparam logic [1:0] FN_LOOKUP  = 2'd0;
    localparam logic [1:0] FN_CREATE  = 2'd1;
    localparam logic [1:0] FN_RELEASE = 2'd2;

    localparam logic [2:0] OUT_HIT      = 3'd0;
    localparam logic [2:0] OUT_MISS     = 3'd1;
    localparam logic [2:0] OUT_CREATED  = 3'd2;
    localparam logic [2:0] OUT_NOROOM   = 3'd3;
    localparam logic [2:0] OUT_RELEASED = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [23:0] domain_key;
        logic [15:0] client_key;
        logic [4:0]  qtype_key;
        logic [7:0]  release_index;
    } req_t;

    typedef struct packed {
        logic [2:0] outcome;
        logic [7:0] entry_index;
    } resp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/kcfi_ram.sv */
// generic single-write, single-read ram with registered read data
module kcfi_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/keyed_cache_find_or_insert.sv */
// keyed find-or-insert table: top level with scan sequencer
//
// usage: a request arrives on req (req_valid / req_stall) and yields exactly one
// response on resp (resp_valid / resp_stall). a lookup walks the slots below the
// fill count in index order, one slot per cycle through the single read port of
// the entry ram, and stops at the first valid slot whose key matches.
// lookup-or-create then takes the lowest free slot seen, or appends at the fill
// count. release clears the valid mark of one slot.
// a release goes straight to the done state. a lookup or create walks the slots in
// the scan state and goes to done on a hit, else through the decide state after the
// last slot; with an empty table it goes straight to decide. one request is in
// flight at a time; the block is idle again as resp_valid rises, so the next one
// can be taken then, and the slot walk sets how long a request occupies the block.
// reset clears the fill count but no slot; slots at or above it are never read, so no
// clearing pass runs and the block takes a request in the first cycle after reset.
// when the receiver stalls, the response stays in its register and a finished
// request waits in the done state; a new request is taken once that one is out.
module keyed_cache_find_or_insert #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  kcfi_pkg::req_t req,
    output logic          resp_valid,
    input  logic          resp_stall,
    output kcfi_pkg::resp_t resp
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int WW = kcfi_pkg::KEY_W + 1;

    kcfi_pkg::state_t state_reg, state_next;
    logic [IW:0]      fill_reg, fill_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic             free_found_reg, free_found_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    logic [1:0]       func_reg, func_next;
    logic [kcfi_pkg::KEY_W-1:0] key_reg, key_next;
    logic [2:0]       res_outcome_reg, res_outcome_next;
    logic [7:0]       res_index_reg, res_index_next;
    logic             resp_valid_reg, resp_valid_next;
    kcfi_pkg::resp_t  resp_reg, resp_next;

    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [WW-1:0]    ram_wdata;
    logic             ram_re;
    logic [IW-1:0]    ram_raddr;
    logic [WW-1:0]    ram_rdata;

    logic             hit;
    logic             last;
    logic             resp_free;

    kcfi_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign hit       = ram_rdata[WW-1] && (ram_rdata[kcfi_pkg::KEY_W-1:0] == key_reg);
    assign last      = ({1'b0, idx_reg} + (IW+1)'(1)) == fill_reg;
    assign resp_free = !resp_valid_reg || !resp_stall;
    assign req_stall = (state_reg != kcfi_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kcfi_pkg::ST_IDLE;
            fill_reg       <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        func_reg        <= func_next;
        key_reg         <= key_next;
        res_outcome_reg <= res_outcome_next;
        res_index_reg   <= res_index_next;
        resp_reg        <= resp_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        idx_next         = idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        func_next        = func_reg;
        key_next         = key_reg;
        res_outcome_next = res_outcome_reg;
        res_index_next   = res_index_reg;
        resp_valid_next  = resp_valid_reg && resp_stall;
        resp_next        = resp_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        unique case (state_reg)
            kcfi_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    func_next       = req.func;
                    key_next        = {req.domain_key, req.client_key, req.qtype_key};
                    free_found_next = 1'b0;
                    idx_next        = '0;
                    if (req.func == kcfi_pkg::FN_RELEASE)
                    begin
                        // out-of-table index changes nothing but still answers
                        if (32'(req.release_index) < 32'(TABLE_ENTRIES))
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = IW'(req.release_index);
                        end
                        res_outcome_next = kcfi_pkg::OUT_RELEASED;
                        res_index_next   = req.release_index;
                        state_next       = kcfi_pkg::ST_DONE;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = kcfi_pkg::ST_DECIDE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = kcfi_pkg::ST_SCAN;
                    end
                end
            end
            kcfi_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    res_outcome_next = kcfi_pkg::OUT_HIT;
                    res_index_next   = 8'(idx_reg);
                    state_next       = kcfi_pkg::ST_DONE;
                end
                else
                begin
                    if (!ram_rdata[WW-1] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (last)
                    begin
                        state_next = kcfi_pkg::ST_DECIDE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + 1'b1;
                    end
                end
            end
            kcfi_pkg::ST_DECIDE:
            begin
                state_next = kcfi_pkg::ST_DONE;
                if (func_reg == kcfi_pkg::FN_CREATE)
                begin
                    if (free_found_reg)
                    begin
                        ram_we           = 1'b1;
                        ram_waddr        = free_idx_reg;
                        ram_wdata        = {1'b1, key_reg};
                        res_outcome_next = kcfi_pkg::OUT_CREATED;
                        res_index_next   = 8'(free_idx_reg);
                    end
                    else if (fill_reg < (IW+1)'(TABLE_ENTRIES))
                    begin
                        ram_we           = 1'b1;
                        ram_waddr        = IW'(fill_reg);
                        ram_wdata        = {1'b1, key_reg};
                        fill_next        = fill_reg + 1'b1;
                        res_outcome_next = kcfi_pkg::OUT_CREATED;
                        res_index_next   = 8'(fill_reg);
                    end
                    else
                    begin
                        res_outcome_next = kcfi_pkg::OUT_NOROOM;
                        res_index_next   = '0;
                    end
                end
                else
                begin
                    res_outcome_next = kcfi_pkg::OUT_MISS;
                    res_index_next   = '0;
                end
            end
            kcfi_pkg::ST_DONE:
            begin
                if (resp_free)
                begin
                    resp_valid_next       = 1'b1;
                    resp_next.outcome     = res_outcome_reg;
                    resp_next.entry_index = res_index_reg;
                    state_next            = kcfi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kcfi_pkg::ST_IDLE;
            end
        endcase
    end

    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

endmodule

/* hw/rtl/kcfi_checker.sv */
// port-level checker for the keyed find-or-insert table, with its bind
`include "assert_macros.svh"

module kcfi_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input kcfi_pkg::req_t  req,
    input logic            resp_valid,
    input logic            resp_stall,
    input kcfi_pkg::resp_t resp
);

    logic req_taken;
    logic resp_held;
    logic no_index;

    assign req_taken = req_valid && !req_stall && (req.func == req.func);
    assign resp_held = resp_valid && resp_stall;
    assign no_index  = (resp.outcome == kcfi_pkg::OUT_MISS) ||
                       (resp.outcome == kcfi_pkg::OUT_NOROOM);

    `ASSERT_NEXT(a_resp_hold, resp_held, resp_valid && $stable(resp))
    `ASSERT_NEXT(a_busy_after_accept, req_taken, req_stall)
    `ASSERT_IMPLY(a_outcome_range, resp_valid, resp.outcome <= kcfi_pkg::OUT_RELEASED)
    `ASSERT_IMPLY(a_zero_index, resp_valid && no_index, resp.entry_index == 8'd0)

endmodule

bind keyed_cache_find_or_insert kcfi_checker u_checker (.*);

/* tb/sv/tb_top.sv */
// testbench for the keyed find-or-insert table: directed and random requests checked by a local table model
module tb_top;
    import kcfi_pkg::*;

    localparam int          TABLE_SLOTS = 256;
    localparam logic [1:0]  FN_SPARE    = 2'd3;
    localparam int          CYCLE_LIMIT = 2500000;
    localparam int          DRAIN_WAIT  = TABLE_SLOTS + 40;
    localparam int          PRINT_LIMIT = 40;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req = '0;
    logic  resp_valid;
    logic  resp_stall = 1'b0;
    resp_t resp;

    keyed_cache_find_or_insert #(
        .TABLE_ENTRIES(TABLE_SLOTS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .resp       (resp)
    );

    // model of the table contents
    logic [KEY_W-1:0] slot_key [TABLE_SLOTS];
    logic             slot_used [TABLE_SLOTS];
    int               fill_level = 0;

    req_t             pending_requests [$];
    resp_t            expected_answers [$];
    logic [KEY_W-1:0] known_keys [$];

    logic req_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   mismatches = 0;
    int   cycle_count = 0;
    int   requests_sent = 0;
    int   outcome_seen [8];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        mismatches++;
    endtask

    // walk the table the way the block does and return the answer it must give
    function automatic resp_t table_access(input req_t r);
        resp_t            a;
        logic [KEY_W-1:0] k;
        int               hit_at;
        int               free_at;
        a = '0;
        k = {r.domain_key, r.client_key, r.qtype_key};
        if (r.func == FN_RELEASE)
        begin
            if (int'(r.release_index) < TABLE_SLOTS)
            begin
                slot_used[r.release_index] = 1'b0;
            end
            a.outcome = OUT_RELEASED;
            a.entry_index = r.release_index;
            return a;
        end
        hit_at = -1;
        free_at = -1;
        for (int s = 0; s < fill_level; s++)
        begin
            if (slot_used[s] && slot_key[s] == k && hit_at < 0)
            begin
                hit_at = s;
            end
            if (!slot_used[s] && free_at < 0)
            begin
                free_at = s;
            end
        end
        if (hit_at >= 0)
        begin
            a.outcome = OUT_HIT;
            a.entry_index = hit_at[7:0];
        end
        else if (r.func != FN_CREATE)
        begin
            a.outcome = OUT_MISS;
        end
        else if (free_at < 0 && fill_level >= TABLE_SLOTS)
        begin
            a.outcome = OUT_NOROOM;
        end
        else
        begin
            if (free_at < 0)
            begin
                free_at = fill_level;
                fill_level++;
            end
            slot_key[free_at] = k;
            slot_used[free_at] = 1'b1;
            a.outcome = OUT_CREATED;
            a.entry_index = free_at[7:0];
        end
        return a;
    endfunction

    task automatic check_answer(input resp_t got);
        resp_t want;
        if (got.outcome <= OUT_RELEASED)
        begin
            outcome_seen[got.outcome]++;
        end
        if (expected_answers.size() == 0)
        begin
            report_mismatch($sformatf("response outcome %0d index %0d with no request outstanding",
                                      got.outcome, got.entry_index));
        end
        else
        begin
            want = expected_answers.pop_front();
            if (got.outcome !== want.outcome)
            begin
                report_mismatch($sformatf("outcome %0d, expected %0d",
                                          got.outcome, want.outcome));
            end
            if (got.entry_index !== want.entry_index)
            begin
                report_mismatch($sformatf("entry_index %0d, expected %0d",
                                          got.entry_index, want.entry_index));
            end
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_taken)
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req <= pending_requests.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
        resp_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        req_taken <= rst_n && req_valid && !req_stall;
        if (rst_n)
        begin
            if (resp_valid && !resp_stall)
            begin
                check_answer(resp);
            end
            if (req_valid && !req_stall)
            begin
                expected_answers.push_back(table_access(req));
                requests_sent++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_request(input logic [1:0] f, input logic [23:0] d,
                                 input logic [15:0] c, input logic [4:0] q,
                                 input logic [7:0] ri);
        req_t r;
        r.func = f;
        r.domain_key = d;
        r.client_key = c;
        r.qtype_key = q;
        r.release_index = ri;
        if (f == FN_CREATE)
        begin
            known_keys.push_back({d, c, q});
        end
        pending_requests.push_back(r);
    endtask

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [63:0] bits;
        bits = {$urandom(), $urandom()};
        return bits[KEY_W-1:0];
    endfunction

    // mostly keys seen before so hits and re-creates happen, the rest fresh
    task automatic queue_random_request();
        int               roll;
        int               span;
        logic [1:0]       f;
        logic [KEY_W-1:0] k;
        logic [7:0]       ri;
        roll = $urandom_range(99);
        if (roll < 40)
        begin
            f = FN_CREATE;
        end
        else if (roll < 70)
        begin
            f = FN_LOOKUP;
        end
        else if (roll < 92)
        begin
            f = FN_RELEASE;
        end
        else
        begin
            f = FN_SPARE;
        end
        k = fresh_key();
        if (known_keys.size() != 0 && $urandom_range(99) < 65)
        begin
            k = known_keys[$urandom_range(known_keys.size() - 1)];
        end
        span = (known_keys.size() > 255) ? 255 : known_keys.size();
        ri = ($urandom_range(99) < 70) ? 8'($urandom_range(span)) : 8'($urandom_range(255));
        queue_request(f, k[44:21], k[20:5], k[4:0], ri);
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || req_valid || expected_answers.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            slot_used[s] = 1'b0;
            slot_key[s] = '0;
        end
        foreach (outcome_seen[i])
        begin
            outcome_seen[i] = 0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, key extremes, spare code, holes, idle releases
        queue_request(FN_LOOKUP, 24'h0, 16'h0, 5'h0, 8'hFF);
        queue_request(FN_SPARE, 24'hFFFFFF, 16'hFFFF, 5'h1F, 8'h00);
        queue_request(FN_CREATE, 24'h0, 16'h0, 5'h0, 8'h55);
        queue_request(FN_CREATE, 24'hFFFFFF, 16'hFFFF, 5'h1F, 8'hAA);
        queue_request(FN_CREATE, 24'hFFFFFF, 16'h0, 5'h0, 8'h0);
        queue_request(FN_CREATE, 24'h0, 16'hFFFF, 5'h0, 8'hFF);
        queue_request(FN_CREATE, 24'h0, 16'h0, 5'h1F, 8'h0);
        queue_request(FN_LOOKUP, 24'hFFFFFF, 16'hFFFF, 5'h1F, 8'h0);
        queue_request(FN_SPARE, 24'h0, 16'h0, 5'h0, 8'hFF);
        queue_request(FN_CREATE, 24'hFFFFFF, 16'hFFFF, 5'h1F, 8'h0);
        queue_request(FN_RELEASE, 24'h0, 16'h0, 5'h0, 8'd1);
        queue_request(FN_LOOKUP, 24'hFFFFFF, 16'hFFFF, 5'h1F, 8'h0);
        queue_request(FN_RELEASE, 24'hFFFFFF, 16'hFFFF, 5'h1F, 8'd1);
        queue_request(FN_RELEASE, 24'h123456, 16'h789A, 5'h0B, 8'd255);
        queue_request(FN_CREATE, 24'h5A5A5A, 16'hA5A5, 5'h15, 8'h0);
        queue_request(FN_CREATE, 24'hA5A5A5, 16'h5A5A, 5'h0A, 8'h0);
        queue_request(FN_LOOKUP, 24'hA5A5A5, 16'h5A5A, 5'h0A, 8'h0);
        queue_request(FN_RELEASE, 24'hFFFFFF, 16'hFFFF, 5'h1F, 8'd0);
        queue_request(FN_LOOKUP, 24'h0, 16'h0, 5'h0, 8'h0);
        queue_request(FN_RELEASE, 24'h0, 16'h0, 5'h0, 8'hAA);
        queue_request(FN_CREATE, 24'h000001, 16'h0001, 5'h01, 8'h80);
        drain();

        // random: no idling
        repeat (330) queue_random_request();
        drain();

        // random with a sending side that is mostly idle
        send_idle_pct = 85;
        repeat (330) queue_random_request();
        drain();

        // receiver stalls: fill the table to capacity, then mixed traffic on the full table
        send_idle_pct = 0;
        recv_stall_pct = 85;
        repeat (300)
        begin
            queue_request(FN_CREATE, 24'($urandom()), 16'($urandom()), 5'($urandom()),
                          8'($urandom_range(255)));
        end
        repeat (60) queue_random_request();
        drain();

        // both sides idling
        send_idle_pct = 38;
        recv_stall_pct = 38;
        repeat (330) queue_random_request();
        drain();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_answers.size() != 0)
        begin
            report_mismatch($sformatf("%0d responses never arrived", expected_answers.size()));
        end

        $display("ran %0d requests through four idle and stall mixes, table filled to %0d slots",
                 requests_sent, fill_level);
        $display("responses: hit %0d, miss %0d, created %0d, no room %0d, released %0d",
                 outcome_seen[OUT_HIT], outcome_seen[OUT_MISS], outcome_seen[OUT_CREATED],
                 outcome_seen[OUT_NOROOM], outcome_seen[OUT_RELEASED]);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* keyed_cache_find_or_insert.f */
+incdir+hw/rtl
hw/rtl/kcfi_pkg.sv
hw/rtl/kcfi_ram.sv
hw/rtl/keyed_cache_find_or_insert.sv
hw/rtl/kcfi_checker.sv
tb/sv/tb_top.sv
